### hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the decoder.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion label failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion label failed");

`endif

### hw/rtl/lzrle_pkg.sv
// Shared constants and types of the LZSS/RLE stream decoder.
// No dependencies; used by the controller, datapath, checker and top level.
package lzrle_pkg;

	localparam int WIN_AW      = 16;
	localparam int LANE_BYTES  = 8;
	localparam int OFFSET_BIAS = 259;
	localparam int MIN_MATCH   = 3;
	localparam int CNT_W       = 9;
	localparam int FILL_W      = 4;
	localparam int TDATA_W     = 72;

	localparam logic [15:0] END_MARK  = 16'h0100;
	localparam logic [7:0]  FILL_BYTE = 8'hFF;
	localparam logic [7:0]  LIT_MASK  = 8'h80;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_LIT,
		KIND_RLE,
		KIND_COPY,
		KIND_END
	} kind_t;

	typedef struct packed {
		logic take;
		logic rd;
		logic emit;
		logic flush;
		logic end_mark;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  cnt_one;
		logic  cnt_zero;
		logic  fill_seven;
		logic  copy;
		logic  out_free;
	} status_t;

endpackage

### hw/rtl/lzss_rle_stream_decoder.sv
// Top level of the LZSS/RLE stream decoder with a 64K history window.
// Depends on lzrle_pkg, lzrle_ctrl and lzrle_dp.
//
// Usage:
//   The s_ channel takes one compressed byte per item. The m_ channel gives
//   up to eight decompressed bytes per item, first byte in tdata[7:0];
//   tlast marks the final item caused by one input byte, tuser marks the
//   end-of-stream item (byte count 0).
//   Throughput: a byte that does not complete a token is accepted while the
//   decoder stays ready. A literal or run then emits one byte per cycle plus
//   a flush step per item, which waits while the output register is full;
//   a window copy does a window read, then a write, per byte, plus a flush
//   step per item. Each item is registered for m_ at its flush step.
//   s_tready is low while a token expands; the next byte is taken while a
//   finished item still waits on m_.
//   Stall: when m_tready is low and an item waits, the decoder holds its
//   next lane and waits; nothing is lost.
//   Reset: the parser waits for a flag byte and the window reads as 0xFF
//   everywhere; a fill mark tracks written entries, so no clearing pass.
//   After the end marker all input bytes are accepted and dropped.
module lzss_rle_stream_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] in_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lzrle_pkg::TDATA_W-1:0] m_tdata,  // [63:0] out_bytes, [67:64] byte_count
	output logic                          m_tlast,
	output logic                          m_tuser   // [0] end_of_stream
);

	lzrle_pkg::cmd_t    cmd;
	lzrle_pkg::status_t st;

	lzrle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	lzrle_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (s_tdata),
		.cmd      (cmd),
		.st       (st),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

### hw/rtl/lzrle_ctrl.sv
// Sequencing state machine of the decoder.
// Depends on lzrle_pkg; drives datapath commands from its status.
module lzrle_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  lzrle_pkg::status_t st,
	output lzrle_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_GEN,
		S_FLUSH,
		S_END,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign s_tready = (state_q == S_IDLE) || (state_q == S_DONE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					case (st.kind)
						lzrle_pkg::KIND_LIT,
						lzrle_pkg::KIND_RLE:  state_d = S_GEN;
						lzrle_pkg::KIND_COPY: state_d = S_RD;
						lzrle_pkg::KIND_END:  state_d = S_END;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_GEN;
			end
			S_GEN: begin
				cmd.emit = 1'b1;
				if (st.cnt_one || st.fill_seven) begin
					state_d = S_FLUSH;
				end else begin
					state_d = st.copy ? S_RD : S_GEN;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.flush = 1'b1;
					if (st.cnt_zero) begin
						state_d = S_IDLE;
					end else begin
						state_d = st.copy ? S_RD : S_GEN;
					end
				end
			end
			S_END: begin
				if (st.out_free) begin
					cmd.end_mark = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: state_d = S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hw/rtl/lzrle_dp.sv
// Datapath of the decoder: token parser, 64K history window, byte lane and
// output register. Depends on lzrle_pkg; commanded by lzrle_ctrl.
module lzrle_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        in_byte,
	input  lzrle_pkg::cmd_t                   cmd,
	output lzrle_pkg::status_t                st,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [lzrle_pkg::TDATA_W-1:0]     m_tdata,
	output logic                              m_tlast,
	output logic                              m_tuser
);

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_LEN,
		PH_VLO,
		PH_VHI
	} phase_t;

	localparam int LANE_W = 8 * lzrle_pkg::LANE_BYTES;

	phase_t                       phase_q;
	logic [7:0]                   flag_q;
	logic [3:0]                   tokens_q;
	logic [3:0]                   tokens_d;
	logic [7:0]                   len_q;
	logic [7:0]                   vlo_q;
	logic [15:0]                  value;

	logic [lzrle_pkg::WIN_AW-1:0] wp_q;
	logic [lzrle_pkg::WIN_AW-1:0] src_q;
	logic                         wrapped_q;
	logic [lzrle_pkg::CNT_W-1:0]  cnt_q;
	logic                         copy_q;
	logic [7:0]                   byte_q;

	logic [7:0]                   win_mem [2**lzrle_pkg::WIN_AW];
	logic [7:0]                   rdata_q;
	logic                         rd_ok_q;
	logic [7:0]                   emit_byte;

	logic [LANE_W-1:0]            lane_q;
	logic [lzrle_pkg::FILL_W-1:0] fill_q;

	logic                         out_valid_q;
	logic [LANE_W-1:0]            out_bytes_q;
	logic [lzrle_pkg::FILL_W-1:0] out_cnt_q;
	logic                         out_last_q;
	logic                         out_eos_q;

	assign value     = {in_byte, vlo_q};
	assign tokens_d  = (tokens_q != 4'd0) ? tokens_q - 4'd1 : 4'd0;
	assign emit_byte = copy_q ? (rd_ok_q ? rdata_q : lzrle_pkg::FILL_BYTE) : byte_q;

	always_comb begin
		st.kind = lzrle_pkg::KIND_NONE;
		case (phase_q)
			PH_LEN: begin
				if ((flag_q & lzrle_pkg::LIT_MASK) != 8'd0) st.kind = lzrle_pkg::KIND_LIT;
			end
			PH_VHI: begin
				if (value == lzrle_pkg::END_MARK) begin
					st.kind = lzrle_pkg::KIND_END;
				end else if (value < lzrle_pkg::END_MARK) begin
					st.kind = lzrle_pkg::KIND_RLE;
				end else begin
					st.kind = lzrle_pkg::KIND_COPY;
				end
			end
			default: st.kind = lzrle_pkg::KIND_NONE;
		endcase
		st.cnt_one    = (cnt_q == lzrle_pkg::CNT_W'(1));
		st.cnt_zero   = (cnt_q == '0);
		st.fill_seven = (fill_q == lzrle_pkg::FILL_W'(lzrle_pkg::LANE_BYTES - 1));
		st.copy       = copy_q;
		st.out_free   = !out_valid_q || m_tready;
	end

	// parser and token registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FLAG;
			flag_q   <= '0;
			tokens_q <= '0;
			len_q    <= '0;
			vlo_q    <= '0;
			cnt_q    <= '0;
			copy_q   <= 1'b0;
			byte_q   <= '0;
			src_q    <= '0;
		end else begin
			if (cmd.take) begin
				case (phase_q)
					PH_FLAG: begin
						flag_q   <= in_byte;
						tokens_q <= 4'd8;
						phase_q  <= PH_LEN;
					end
					PH_LEN: begin
						if ((flag_q & lzrle_pkg::LIT_MASK) != 8'd0) begin
							byte_q   <= in_byte;
							cnt_q    <= lzrle_pkg::CNT_W'(1);
							copy_q   <= 1'b0;
							flag_q   <= {flag_q[6:0], 1'b0};
							tokens_q <= tokens_d;
							phase_q  <= (tokens_d != 4'd0) ? PH_LEN : PH_FLAG;
						end else begin
							len_q   <= in_byte;
							phase_q <= PH_VLO;
						end
					end
					PH_VLO: begin
						vlo_q   <= in_byte;
						phase_q <= PH_VHI;
					end
					PH_VHI: begin
						if (value != lzrle_pkg::END_MARK) begin
							byte_q   <= vlo_q;
							cnt_q    <= lzrle_pkg::CNT_W'(len_q)
								+ lzrle_pkg::CNT_W'(lzrle_pkg::MIN_MATCH + 1);
							copy_q   <= (value > lzrle_pkg::END_MARK);
							src_q    <= wp_q + lzrle_pkg::WIN_AW'(lzrle_pkg::OFFSET_BIAS - 1)
								- value;
							flag_q   <= {flag_q[6:0], 1'b0};
							tokens_q <= tokens_d;
							phase_q  <= (tokens_d != 4'd0) ? PH_LEN : PH_FLAG;
						end
					end
					default: phase_q <= PH_FLAG;
				endcase
			end
			if (cmd.rd) src_q <= src_q + lzrle_pkg::WIN_AW'(1);
			if (cmd.emit) cnt_q <= cnt_q - lzrle_pkg::CNT_W'(1);
		end
	end

	// history window; entries at or above the write pointer read as the
	// reset fill until the pointer has wrapped once
	always_ff @(posedge clk) begin
		if (cmd.emit) win_mem[wp_q] <= emit_byte;
		if (cmd.rd) begin
			rdata_q <= win_mem[src_q];
			rd_ok_q <= wrapped_q || (src_q < wp_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			lane_q    <= '0;
			fill_q    <= '0;
		end else begin
			if (cmd.emit) begin
				wp_q <= wp_q + lzrle_pkg::WIN_AW'(1);
				if (wp_q == '1) wrapped_q <= 1'b1;
				lane_q[{fill_q[2:0], 3'b000} +: 8] <= emit_byte;
				fill_q <= fill_q + lzrle_pkg::FILL_W'(1);
			end
			if (cmd.flush) begin
				lane_q <= '0;
				fill_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.flush || cmd.end_mark) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			out_bytes_q <= lane_q;
			out_cnt_q   <= fill_q;
			out_last_q  <= st.cnt_zero;
			out_eos_q   <= 1'b0;
		end else if (cmd.end_mark) begin
			out_bytes_q <= '0;
			out_cnt_q   <= '0;
			out_last_q  <= 1'b1;
			out_eos_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(lzrle_pkg::TDATA_W - LANE_W - lzrle_pkg::FILL_W){1'b0}},
		out_cnt_q, out_bytes_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_eos_q;

endmodule

### hw/rtl/lzrle_chk.sv
// Port-level checker of the decoder, bound to the top level.
// Depends on lzrle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lzrle_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lzrle_pkg::TDATA_W-1:0] m_tdata,
	input logic                          m_tlast,
	input logic                          m_tuser
);

	logic [3:0] byte_cnt;

	assign byte_cnt = m_tdata[67:64];

	`CHK_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`CHK_IMPLIES(a_eos_shape, clk, arst_n, m_tvalid && m_tuser, m_tlast && (byte_cnt == 4'd0))
	`CHK_IMPLIES(a_count_range, clk, arst_n, m_tvalid && !m_tuser, (byte_cnt != 4'd0) && (byte_cnt <= 4'd8))
	`CHK_NEXT(a_quiet_after_eos, clk, arst_n, m_tvalid && m_tready && m_tuser, !m_tvalid)
	`CHK_IMPLIES(a_ready_after_eos, clk, arst_n, m_tvalid && m_tuser, s_tready)

endmodule

bind lzss_rle_stream_decoder lzrle_chk u_chk (.*);
